@@ src/rtrw_pkg.sv @@
// ----------------------------------------------------------------------------
// Route table package
// Shared constants, codes and word types of the routing table block.
// ----------------------------------------------------------------------------
package rtrw_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 32;

    localparam logic [15:0] OWN_NODE_ID_RESET = 16'd1;
    localparam logic [31:0] ROUTE_TIMEOUT_RESET = 32'd60000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OWN_NODE_ID   = 1'b0,
        CFG_ROUTE_TIMEOUT = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        FN_UPDATE = 2'd0,
        FN_LOOKUP = 2'd1,
        FN_AGE    = 2'd2,
        FN_NONE   = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WORST,
        ST_DECIDE,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] dest_node;
        logic [15:0] via_node;
        logic [7:0]  hops;
        logic [7:0]  link_quality;
        logic [31:0] now_ms;
    } t_req_word;

    typedef struct packed {
        logic             accepted;
        logic             found;
        logic [15:0]      found_via;
        logic [7:0]       found_hops;
        logic [7:0]       found_quality;
        logic [CNT_W-1:0] entries_used;
        logic [CNT_W-1:0] removed_count;
    } t_rsp_word;

    typedef struct packed {
        logic [15:0] dest;
        logic [15:0] via;
        logic [7:0]  hops;
        logic [7:0]  quality;
        logic [31:0] stamp;
    } t_entry;

endpackage

@@ src/rtrw_req_if.sv @@
// ----------------------------------------------------------------------------
// Route table request channel
// Valid/ready channel that carries one request word.
// ----------------------------------------------------------------------------
interface rtrw_req_if import rtrw_pkg::*;;
    logic      valid;
    logic      ready;
    t_req_word data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ src/rtrw_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Route table response channel
// Valid/ready channel that carries one response word.
// ----------------------------------------------------------------------------
interface rtrw_rsp_if import rtrw_pkg::*;;
    logic      valid;
    logic      ready;
    t_rsp_word data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ src/rtrw_cmp.sv @@
// ----------------------------------------------------------------------------
// Route compare unit
// Tells whether route a beats route b: fewer hops, or equal hops and
// higher quality.
// ----------------------------------------------------------------------------
module rtrw_cmp (
    input  logic [7:0] i_a_hops,
    input  logic [7:0] i_a_quality,
    input  logic [7:0] i_b_hops,
    input  logic [7:0] i_b_quality,
    output logic       o_beats
);

    assign o_beats = (i_a_hops < i_b_hops) ||
                     ((i_a_hops == i_b_hops) && (i_a_quality > i_b_quality));

endmodule

@@ src/route_table_replace_worst.sv @@
// ----------------------------------------------------------------------------
// Routing table with worst-entry replacement
// Ordered distance-vector routing table, scanned one entry per cycle.
//
// A request word enters on i_req and one response word leaves on o_rsp for
// each request. The table is a memory with one read and one write port and
// a registered read, scanned by a small sequencer that issues one read per
// cycle and checks the previous read in the same cycle; one compare unit
// serves both the worst-entry search and the final better-route decision.
// A lookup scans until it hits the destination or passes the last entry; an
// age operation scans all valid entries and compacts the kept ones; an update
// scans for the destination and, if the table is full and none matches, again
// for the worst entry. An own-id update or an unused code skips the scan.
// The block takes one request at a time: i_req.ready is high only while no
// request is in work and no response waits. A new request is taken in the
// cycle after a response word leaves, so requests never overlap.
// If the receiver stalls, the response holds on o_rsp until it is taken.
// Reset empties the table and loads the default node id and timeout.
// Configuration is written through i_cfg_we, i_cfg_idx and i_cfg_data.
// ----------------------------------------------------------------------------
module route_table_replace_worst import rtrw_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    rtrw_req_if.sink              i_req,
    rtrw_rsp_if.source            o_rsp
);

    t_state           r_state, n_state;
    t_req_word        r_req, n_req;
    logic [15:0]      r_own;
    logic [31:0]      r_timeout;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_issue, n_issue;
    logic [CNT_W-1:0] r_wr, n_wr;
    logic             r_eval_valid, n_eval_valid;
    logic [IDX_W-1:0] r_eval_idx, n_eval_idx;
    t_entry           r_ref, n_ref;
    logic [IDX_W-1:0] r_ref_idx, n_ref_idx;
    logic             r_acc, n_acc;
    logic             r_found, n_found;
    logic [CNT_W-1:0] r_removed, n_removed;

    t_entry           r_mem [TABLE_DEPTH];
    t_entry           r_rd_data;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [IDX_W-1:0] mem_raddr;
    t_entry           mem_wdata;

    logic             req_accept;
    logic             hit;
    logic             scan_end;
    logic             stale;
    logic [31:0]      age;
    logic             room;
    logic [7:0]       cmp_a_hops, cmp_a_quality, cmp_b_hops, cmp_b_quality;
    logic             cmp_beats;
    t_entry           new_entry;

    assign req_accept = i_req.valid && i_req.ready;
    assign hit        = r_eval_valid && (r_rd_data.dest == r_req.dest_node);
    assign scan_end   = !r_eval_valid && (r_issue >= r_count);
    assign age        = r_req.now_ms - r_rd_data.stamp;
    assign stale      = age > r_timeout;
    assign room       = r_count < CNT_W'(TABLE_DEPTH);

    assign new_entry.dest     = r_req.dest_node;
    assign new_entry.via      = r_req.via_node;
    assign new_entry.hops     = r_req.hops;
    assign new_entry.quality  = r_req.link_quality;
    assign new_entry.stamp    = r_req.now_ms;

    always_comb begin
        if (r_state == ST_WORST) begin
            cmp_a_hops    = r_ref.hops;
            cmp_a_quality = r_ref.quality;
            cmp_b_hops    = r_rd_data.hops;
            cmp_b_quality = r_rd_data.quality;
        end else begin
            cmp_a_hops    = r_req.hops;
            cmp_a_quality = r_req.link_quality;
            cmp_b_hops    = r_ref.hops;
            cmp_b_quality = r_ref.quality;
        end
    end

    rtrw_cmp u_cmp (
        .i_a_hops    (cmp_a_hops),
        .i_a_quality (cmp_a_quality),
        .i_b_hops    (cmp_b_hops),
        .i_b_quality (cmp_b_quality),
        .o_beats     (cmp_beats)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (req_accept) begin
                    if ((t_func'(i_req.data.func) == FN_UPDATE &&
                         i_req.data.dest_node == r_own) ||
                        t_func'(i_req.data.func) == FN_NONE) begin
                        n_state = ST_RESP;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (t_func'(r_req.func) != FN_AGE && hit) begin
                    n_state = (t_func'(r_req.func) == FN_UPDATE) ? ST_DECIDE : ST_RESP;
                end else if (scan_end) begin
                    if (t_func'(r_req.func) == FN_UPDATE && !room) begin
                        n_state = ST_WORST;
                    end else begin
                        n_state = ST_RESP;
                    end
                end
            end
            ST_WORST: begin
                if (scan_end) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                n_state = ST_RESP;
            end
            ST_RESP: begin
                if (o_rsp.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_req        = r_req;
        n_count      = r_count;
        n_issue      = r_issue;
        n_wr         = r_wr;
        n_eval_valid = 1'b0;
        n_eval_idx   = r_eval_idx;
        n_ref        = r_ref;
        n_ref_idx    = r_ref_idx;
        n_acc        = r_acc;
        n_found      = r_found;
        n_removed    = r_removed;
        mem_we       = 1'b0;
        mem_waddr    = r_ref_idx;
        mem_wdata    = new_entry;
        mem_raddr    = r_issue[IDX_W-1:0];

        if ((r_state == ST_SCAN || r_state == ST_WORST) && r_issue < r_count) begin
            n_issue      = r_issue + 1'b1;
            n_eval_valid = 1'b1;
            n_eval_idx   = r_issue[IDX_W-1:0];
        end

        unique case (r_state)
            ST_IDLE: begin
                if (req_accept) begin
                    n_req     = i_req.data;
                    n_issue   = '0;
                    n_wr      = '0;
                    n_acc     = 1'b0;
                    n_found   = 1'b0;
                    n_removed = '0;
                end
            end
            ST_SCAN: begin
                if (t_func'(r_req.func) == FN_AGE) begin
                    if (r_eval_valid && !stale) begin
                        if (r_wr[IDX_W-1:0] != r_eval_idx) begin
                            mem_we    = 1'b1;
                            mem_waddr = r_wr[IDX_W-1:0];
                            mem_wdata = r_rd_data;
                        end
                        n_wr = r_wr + 1'b1;
                    end
                    if (scan_end) begin
                        n_count   = r_wr;
                        n_removed = r_count - r_wr;
                    end
                end else if (hit) begin
                    n_ref     = r_rd_data;
                    n_ref_idx = r_eval_idx;
                    if (t_func'(r_req.func) == FN_LOOKUP) begin
                        n_found = 1'b1;
                    end
                end else if (scan_end && t_func'(r_req.func) == FN_UPDATE) begin
                    if (room) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_count[IDX_W-1:0];
                        n_count   = r_count + 1'b1;
                        n_acc     = 1'b1;
                    end else begin
                        n_issue = '0;
                    end
                end
            end
            ST_WORST: begin
                if (r_eval_valid && (r_eval_idx == '0 || cmp_beats)) begin
                    n_ref     = r_rd_data;
                    n_ref_idx = r_eval_idx;
                end
            end
            ST_DECIDE: begin
                if (cmp_beats) begin
                    mem_we = 1'b1;
                    n_acc  = 1'b1;
                end
            end
            ST_RESP: begin
            end
            default: begin
            end
        endcase
    end

    assign i_req.ready = (r_state == ST_IDLE);
    assign o_rsp.valid = (r_state == ST_RESP);

    assign o_rsp.data.accepted       = r_acc;
    assign o_rsp.data.found          = r_found;
    assign o_rsp.data.found_via      = r_found ? r_ref.via : 16'd0;
    assign o_rsp.data.found_hops     = r_found ? r_ref.hops : 8'd0;
    assign o_rsp.data.found_quality  = r_found ? r_ref.quality : 8'd0;
    assign o_rsp.data.entries_used   = r_count;
    assign o_rsp.data.removed_count  = r_removed;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_count      <= '0;
            r_eval_valid <= 1'b0;
            r_own        <= OWN_NODE_ID_RESET;
            r_timeout    <= ROUTE_TIMEOUT_RESET;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_eval_valid <= n_eval_valid;
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_OWN_NODE_ID:   r_own     <= i_cfg_data[15:0];
                    CFG_ROUTE_TIMEOUT: r_timeout <= i_cfg_data[31:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_issue    <= n_issue;
        r_wr       <= n_wr;
        r_eval_idx <= n_eval_idx;
        r_ref      <= n_ref;
        r_ref_idx  <= n_ref_idx;
        r_acc      <= n_acc;
        r_found    <= n_found;
        r_removed  <= n_removed;
    end

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready |-> !o_rsp.valid)
        else $error("Request taken while a response is pending.");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("Entry count exceeds the table depth.");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> !(o_rsp.data.accepted && o_rsp.data.found))
        else $error("Response flags both set.");

    a_ready_after_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.ready) |=> i_req.ready)
        else $error("Block not ready after a response word was taken.");

endmodule
